// File: rtl/ask4b6b_pkg.sv
package ask4b6b_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_TO    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FROM  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_ID    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_FLAGS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_MSG_LEN  = 3'd4;

   localparam logic [7:0]  RST_HEADER_TO    = 8'd255;
   localparam logic [7:0]  RST_HEADER_FROM  = 8'd255;
   localparam logic [7:0]  RST_HEADER_ID    = 8'd0;
   localparam logic [7:0]  RST_HEADER_FLAGS = 8'd0;
   localparam logic [7:0]  RST_MAX_MSG_LEN  = 8'd60;

   localparam logic [5:0]  SYM_FILL     = 6'h2a;
   localparam logic [5:0]  SYM_SYNC0    = 6'h38;
   localparam logic [5:0]  SYM_SYNC1    = 6'h2c;
   localparam logic [5:0]  SYM_REJECT   = 6'h00;
   localparam logic [15:0] CRC_INIT     = 16'hffff;
   localparam logic [15:0] CRC_POLY     = 16'h8408;
   localparam logic [7:0]  COUNT_OFFSET = 8'd7;
   localparam int unsigned HDR_SYMBOLS  = 10;
   localparam int unsigned FCS_SYMBOLS  = 4;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   typedef enum logic [1:0] {
      CMD_REJECT,
      CMD_START,
      CMD_DATA
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic         fcs;
   } cmd_type;

   typedef struct packed {
      logic [7:0] header_to;
      logic [7:0] header_from;
      logic [7:0] header_id;
      logic [7:0] header_flags;
      logic [7:0] max_msg_len;
   } cfg_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PRE,
      BK_HDR,
      BK_DATA,
      BK_FCS,
      BK_REJ
   } back_state_type;

   function automatic logic [5:0] nibble_symbol(input logic [3:0] nib);
      logic [5:0] sym;
      case (nib)
         4'h0: sym = 6'h0d;
         4'h1: sym = 6'h0e;
         4'h2: sym = 6'h13;
         4'h3: sym = 6'h15;
         4'h4: sym = 6'h16;
         4'h5: sym = 6'h19;
         4'h6: sym = 6'h1a;
         4'h7: sym = 6'h1c;
         4'h8: sym = 6'h23;
         4'h9: sym = 6'h25;
         4'ha: sym = 6'h26;
         4'hb: sym = 6'h29;
         4'hc: sym = 6'h2a;
         4'hd: sym = 6'h2c;
         4'he: sym = 6'h32;
         default: sym = 6'h34;
      endcase
      return sym;
   endfunction

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/ask4b6b_queue.sv
module ask4b6b_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ask4b6b_pkg::cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output ask4b6b_pkg::cmd_type head
);

   localparam int unsigned PW = ask4b6b_pkg::QUEUE_PTR_W;

   ask4b6b_pkg::cmd_type mem_ff [ask4b6b_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(ask4b6b_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ask4b6b_front.sv
module ask4b6b_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic [7:0]           max_msg_len,
   output logic                 push,
   output ask4b6b_pkg::cmd_type push_data,
   input  logic                 q_full
);

   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       accept;
   logic [7:0] payload_len;
   logic [7:0] data_byte;

   assign req_tready  = !q_full;
   assign accept      = req_tvalid && req_tready;
   assign payload_len = req_tdata[7:0];
   assign data_byte   = req_tdata[15:8];

   always_comb begin
      push           = 1'b0;
      push_data.kind = ask4b6b_pkg::CMD_DATA;
      push_data.value = data_byte;
      push_data.fcs  = 1'b0;
      bytes_left_in  = bytes_left_ff;
      if (accept) begin
         if (!req_tuser) begin
            push = 1'b1;
            if (payload_len > max_msg_len) begin
               push_data.kind  = ask4b6b_pkg::CMD_REJECT;
               push_data.value = payload_len;
            end else begin
               push_data.kind  = ask4b6b_pkg::CMD_START;
               push_data.value = payload_len;
               push_data.fcs   = (payload_len == 8'd0);
               bytes_left_in   = payload_len;
            end
         end else if (bytes_left_ff != 8'd0) begin
            push           = 1'b1;
            push_data.fcs  = (bytes_left_ff == 8'd1);
            bytes_left_in  = bytes_left_ff - 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= '0;
      end else begin
         bytes_left_ff <= bytes_left_in;
      end
   end

endmodule

// File: rtl/ask4b6b_back.sv
module ask4b6b_back #(
   parameter int unsigned PREAMBLE_SYMBOLS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ask4b6b_pkg::cfg_type cfg,
   input  logic                 q_valid,
   input  ask4b6b_pkg::cmd_type q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tuser
);

   localparam int unsigned CNT_MAX = (PREAMBLE_SYMBOLS > ask4b6b_pkg::HDR_SYMBOLS) ?
                                     PREAMBLE_SYMBOLS : ask4b6b_pkg::HDR_SYMBOLS;
   localparam int unsigned CNT_W   = $clog2(CNT_MAX);
   localparam logic [CNT_W-1:0] PRE_LAST  = CNT_W'(PREAMBLE_SYMBOLS - 1);
   localparam logic [CNT_W-1:0] PRE_SYNC0 = CNT_W'(PREAMBLE_SYMBOLS - 2);
   localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(ask4b6b_pkg::HDR_SYMBOLS - 1);
   localparam logic [CNT_W-1:0] DATA_LAST = CNT_W'(1);
   localparam logic [CNT_W-1:0] FCS_LAST  = CNT_W'(ask4b6b_pkg::FCS_SYMBOLS - 1);

   ask4b6b_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       value_ff, value_in;
   logic             fcs_ff, fcs_in;
   logic [15:0]      crc_ff, crc_in;
   logic             valid_ff;
   logic [5:0]       sym_ff;
   logic             last_ff, rej_ff;

   logic             advance, emit, finish, load;
   logic [5:0]       sym;
   logic             last, rej, crc_step;
   logic [7:0]       cur_byte;
   logic [15:0]      fcs_word;

   assign advance = !valid_ff || rsp_tready;
   assign emit    = advance && (state_ff != ask4b6b_pkg::BK_IDLE);

   // next state
   always_comb begin
      finish = 1'b0;
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      if (!emit) begin
         cnt_in = cnt_ff;
      end
      case (state_ff)
         ask4b6b_pkg::BK_PRE: begin
            if (emit && cnt_ff == PRE_LAST) begin
               state_in = ask4b6b_pkg::BK_HDR;
               cnt_in   = '0;
            end
         end
         ask4b6b_pkg::BK_HDR: begin
            if (emit && cnt_ff == HDR_LAST) begin
               cnt_in = '0;
               if (fcs_ff) begin
                  state_in = ask4b6b_pkg::BK_FCS;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ask4b6b_pkg::BK_DATA: begin
            if (emit && cnt_ff == DATA_LAST) begin
               cnt_in = '0;
               if (fcs_ff) begin
                  state_in = ask4b6b_pkg::BK_FCS;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         ask4b6b_pkg::BK_FCS: begin
            if (emit && cnt_ff == FCS_LAST) begin
               finish = 1'b1;
            end
         end
         ask4b6b_pkg::BK_REJ: begin
            finish = emit;
         end
         default: begin
            finish = 1'b1;
         end
      endcase
      load = q_valid && finish;
      if (finish) begin
         state_in = ask4b6b_pkg::BK_IDLE;
      end
      value_in = value_ff;
      fcs_in   = fcs_ff;
      if (load) begin
         cnt_in   = '0;
         value_in = q_head.value;
         fcs_in   = q_head.fcs;
         case (q_head.kind)
            ask4b6b_pkg::CMD_REJECT: state_in = ask4b6b_pkg::BK_REJ;
            ask4b6b_pkg::CMD_START:  state_in = ask4b6b_pkg::BK_PRE;
            default:                 state_in = ask4b6b_pkg::BK_DATA;
         endcase
      end
   end

   assign q_pop = load;

   // outputs
   always_comb begin
      sym      = ask4b6b_pkg::SYM_FILL;
      last     = 1'b0;
      rej      = 1'b0;
      crc_step = 1'b0;
      cur_byte = value_ff;
      fcs_word = ~crc_ff;
      case (state_ff)
         ask4b6b_pkg::BK_PRE: begin
            if (cnt_ff == PRE_SYNC0) begin
               sym = ask4b6b_pkg::SYM_SYNC0;
            end else if (cnt_ff == PRE_LAST) begin
               sym = ask4b6b_pkg::SYM_SYNC1;
            end
         end
         ask4b6b_pkg::BK_HDR: begin
            case (cnt_ff[CNT_W-1:1])
               (CNT_W-1)'(0): cur_byte = value_ff + ask4b6b_pkg::COUNT_OFFSET;
               (CNT_W-1)'(1): cur_byte = cfg.header_to;
               (CNT_W-1)'(2): cur_byte = cfg.header_from;
               (CNT_W-1)'(3): cur_byte = cfg.header_id;
               default:       cur_byte = cfg.header_flags;
            endcase
            sym      = ask4b6b_pkg::nibble_symbol(cnt_ff[0] ? cur_byte[3:0] : cur_byte[7:4]);
            crc_step = !cnt_ff[0];
            last     = (cnt_ff == HDR_LAST) && !fcs_ff;
         end
         ask4b6b_pkg::BK_DATA: begin
            sym      = ask4b6b_pkg::nibble_symbol(cnt_ff[0] ? cur_byte[3:0] : cur_byte[7:4]);
            crc_step = !cnt_ff[0];
            last     = (cnt_ff == DATA_LAST) && !fcs_ff;
         end
         ask4b6b_pkg::BK_FCS: begin
            case (cnt_ff[1:0])
               2'd0:    sym = ask4b6b_pkg::nibble_symbol(fcs_word[7:4]);
               2'd1:    sym = ask4b6b_pkg::nibble_symbol(fcs_word[3:0]);
               2'd2:    sym = ask4b6b_pkg::nibble_symbol(fcs_word[15:12]);
               default: sym = ask4b6b_pkg::nibble_symbol(fcs_word[11:8]);
            endcase
            last = (cnt_ff == FCS_LAST);
         end
         ask4b6b_pkg::BK_REJ: begin
            sym  = ask4b6b_pkg::SYM_REJECT;
            last = 1'b1;
            rej  = 1'b1;
         end
         default: begin
            sym = ask4b6b_pkg::SYM_FILL;
         end
      endcase
   end

   always_comb begin
      crc_in = crc_ff;
      if (emit && crc_step) begin
         crc_in = ask4b6b_pkg::crc_update(crc_ff, cur_byte);
      end
      if (emit && state_ff == ask4b6b_pkg::BK_FCS && cnt_ff == FCS_LAST) begin
         crc_in = ask4b6b_pkg::CRC_INIT;
      end
      if (load && q_head.kind == ask4b6b_pkg::CMD_START) begin
         crc_in = ask4b6b_pkg::CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ask4b6b_pkg::BK_IDLE;
         cnt_ff   <= '0;
         crc_ff   <= ask4b6b_pkg::CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         crc_ff   <= crc_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      fcs_ff   <= fcs_in;
      if (emit) begin
         sym_ff  <= sym;
         last_ff <= last;
         rej_ff  <= rej;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, sym_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = rej_ff;

endmodule

// File: rtl/ask_packet_4b6b_framer_top.sv
// Channel   Direction  Handshake              Content
// req       in         req_tvalid/req_tready  tdata: payload_len, data_byte; tuser: req_type
// rsp       out        rsp_tvalid/rsp_tready  tdata: symbol; tlast: last; tuser: rejected
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// A payload byte gives two symbols, six with the FCS, sent one a cycle by the back sequencer
// while rsp is not stalled. A start item gives PREAMBLE_SYMBOLS + 10 symbols, plus 4 when
// the length is zero; a rejected start gives 1. The sequencer sends no symbol while it loads from idle.
// The four-entry command queue lets items enter while earlier symbols still go out.
// Synchronous active-high reset restores the register defaults and empties the queue.
// A stalled rsp holds the sequencer; a full queue deasserts req_tready.
module ask_packet_4b6b_framer_top #(
   parameter int unsigned PREAMBLE_SYMBOLS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] payload_len, [15:8] data_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] symbol, [7:6] zero
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] rejected
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ask4b6b_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]  csr_data
);

   ask4b6b_pkg::cfg_type cfg_ff, cfg_in;
   ask4b6b_pkg::cmd_type push_data, q_head;
   logic push, q_full, q_pop, q_valid;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ask4b6b_pkg::REG_HEADER_TO:    cfg_in.header_to    = csr_data;
            ask4b6b_pkg::REG_HEADER_FROM:  cfg_in.header_from  = csr_data;
            ask4b6b_pkg::REG_HEADER_ID:    cfg_in.header_id    = csr_data;
            ask4b6b_pkg::REG_HEADER_FLAGS: cfg_in.header_flags = csr_data;
            ask4b6b_pkg::REG_MAX_MSG_LEN:  cfg_in.max_msg_len  = csr_data;
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_to    <= ask4b6b_pkg::RST_HEADER_TO;
         cfg_ff.header_from  <= ask4b6b_pkg::RST_HEADER_FROM;
         cfg_ff.header_id    <= ask4b6b_pkg::RST_HEADER_ID;
         cfg_ff.header_flags <= ask4b6b_pkg::RST_HEADER_FLAGS;
         cfg_ff.max_msg_len  <= ask4b6b_pkg::RST_MAX_MSG_LEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ask4b6b_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .max_msg_len (cfg_ff.max_msg_len),
      .push        (push),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   ask4b6b_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   ask4b6b_back #(
      .PREAMBLE_SYMBOLS (PREAMBLE_SYMBOLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef ASSERT_OFF
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == 8'h00))
      else $error("rejected transfer not a lone zero symbol");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> ($countones(rsp_tdata[5:0]) == 3) && (rsp_tdata[7:6] == 2'b00))
      else $error("unbalanced line symbol");

   assert property (@(posedge clock) disable iff (reset)
      push && q_full |-> !(req_tvalid && req_tready))
      else $error("command pushed into full queue");
`endif

endmodule

// File: dv/tb_ask_packet_4b6b_framer_top.sv
`timescale 1ns / 1ps

module tb_ask_packet_4b6b_framer_top;

   localparam int unsigned PREAMBLE_SYMBOLS = 8;
   localparam int unsigned SETTLE_CYCLES    = 48;
   localparam int unsigned HOLD_CYCLES      = 300;
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned LONG_RUN_BYTES   = 32;
   localparam int unsigned PHASE_ITEMS      = 16;
   localparam logic        TYPE_START       = 1'b0;
   localparam logic        TYPE_DATA        = 1'b1;
   localparam logic [5:0]  NIBBLE_CODE [16] = '{
      6'h0d, 6'h0e, 6'h13, 6'h15, 6'h16, 6'h19, 6'h1a, 6'h1c,
      6'h23, 6'h25, 6'h26, 6'h29, 6'h2a, 6'h2c, 6'h32, 6'h34};

   typedef struct packed {
      logic [5:0] symbol;
      logic       last;
      logic       rejected;
   } line_symbol_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata  = '0;   // [7:0] payload_len, [15:8] data_byte
   logic                   req_tuser  = 1'b0; // [0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // [5:0] symbol, [7:6] zero
   logic                   rsp_tlast;
   logic                   rsp_tuser;         // [0] rejected
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [ask4b6b_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_data   = '0;

   line_symbol_type symbols_due[$];
   logic [7:0]   hdr_to       = ask4b6b_pkg::RST_HEADER_TO;
   logic [7:0]   hdr_from     = ask4b6b_pkg::RST_HEADER_FROM;
   logic [7:0]   hdr_id       = ask4b6b_pkg::RST_HEADER_ID;
   logic [7:0]   hdr_flags    = ask4b6b_pkg::RST_HEADER_FLAGS;
   logic [7:0]   len_limit    = ask4b6b_pkg::RST_MAX_MSG_LEN;
   logic [15:0]  fcs_crc      = ask4b6b_pkg::CRC_INIT;
   logic [7:0]   payload_left = 8'd0;

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  hold_request   = 0;
   int  hold_left      = 0;
   int  stall_left     = 0;
   bit  req_gaps       = 1'b1;
   bit  rsp_gaps       = 1'b1;

   ask_packet_4b6b_framer_top #(
      .PREAMBLE_SYMBOLS(PREAMBLE_SYMBOLS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ b[i];
         c  = {1'b0, c[15:1]} ^ (fb ? ask4b6b_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   task automatic emit_symbol(input logic [5:0] sym, input logic rej);
      symbols_due.push_back('{symbol: sym, last: 1'b0, rejected: rej});
   endtask

   task automatic emit_byte(input logic [7:0] b);
      fcs_crc = crc_next(fcs_crc, b);
      emit_symbol(NIBBLE_CODE[b[7:4]], 1'b0);
      emit_symbol(NIBBLE_CODE[b[3:0]], 1'b0);
   endtask

   task automatic emit_fcs();
      logic [15:0] f;
      f = ~fcs_crc;
      emit_symbol(NIBBLE_CODE[f[7:4]], 1'b0);
      emit_symbol(NIBBLE_CODE[f[3:0]], 1'b0);
      emit_symbol(NIBBLE_CODE[f[15:12]], 1'b0);
      emit_symbol(NIBBLE_CODE[f[11:8]], 1'b0);
      fcs_crc = ask4b6b_pkg::CRC_INIT;
   endtask

   task automatic frame_symbols(input logic kind, input logic [7:0] len,
                                input logic [7:0] data);
      line_symbol_type tail;
      if (kind == TYPE_START) begin
         if (len > len_limit) begin
            emit_symbol(ask4b6b_pkg::SYM_REJECT, 1'b1);
         end else begin
            repeat (PREAMBLE_SYMBOLS - 2) emit_symbol(ask4b6b_pkg::SYM_FILL, 1'b0);
            emit_symbol(ask4b6b_pkg::SYM_SYNC0, 1'b0);
            emit_symbol(ask4b6b_pkg::SYM_SYNC1, 1'b0);
            fcs_crc = ask4b6b_pkg::CRC_INIT;
            emit_byte(len + ask4b6b_pkg::COUNT_OFFSET);
            emit_byte(hdr_to);
            emit_byte(hdr_from);
            emit_byte(hdr_id);
            emit_byte(hdr_flags);
            payload_left = len;
            if (len == 8'd0) emit_fcs();
         end
      end else begin
         if (payload_left == 8'd0) return;
         emit_byte(data);
         payload_left = payload_left - 8'd1;
         if (payload_left == 8'd0) emit_fcs();
      end
      tail = symbols_due.pop_back();
      tail.last = 1'b1;
      symbols_due.push_back(tail);
   endtask

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 50) $display("%0t ns  mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      line_symbol_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (symbols_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected symbol transfer tdata=%h", rsp_tdata));
         end else begin
            want = symbols_due.pop_front();
            if (rsp_tdata !== {2'b00, want.symbol})
               flag_mismatch($sformatf("symbol got %h want %h", rsp_tdata, want.symbol));
            if (rsp_tlast !== want.last)
               flag_mismatch($sformatf("last got %b want %b", rsp_tlast, want.last));
            if (rsp_tuser !== want.rejected)
               flag_mismatch($sformatf("rejected got %b want %b", rsp_tuser, want.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps && rsp_tvalid && rsp_tready) begin
         stall_left = $urandom_range(0, 9);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_req(input logic kind, input logic [7:0] len, input logic [7:0] data);
      int gap;
      gap = req_gaps ? $urandom_range(0, 9) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {data, len};
      do @(posedge clock); while (!req_tready);
      frame_symbols(kind, len, data);
   endtask

   task automatic send_start(input logic [7:0] len);
      send_req(TYPE_START, len, 8'($urandom));
   endtask

   task automatic send_data(input logic [7:0] b);
      send_req(TYPE_DATA, 8'($urandom), b);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (symbols_due.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ask4b6b_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         ask4b6b_pkg::REG_HEADER_TO:    hdr_to    = val;
         ask4b6b_pkg::REG_HEADER_FROM:  hdr_from  = val;
         ask4b6b_pkg::REG_HEADER_ID:    hdr_id    = val;
         ask4b6b_pkg::REG_HEADER_FLAGS: hdr_flags = val;
         ask4b6b_pkg::REG_MAX_MSG_LEN:  len_limit = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [7:0] to_v, input logic [7:0] from_v,
                                 input logic [7:0] id_v, input logic [7:0] flags_v,
                                 input logic [7:0] limit_v);
      wait_idle();
      csr_write(ask4b6b_pkg::REG_HEADER_TO, to_v);
      csr_write(ask4b6b_pkg::REG_HEADER_FROM, from_v);
      csr_write(ask4b6b_pkg::REG_HEADER_ID, id_v);
      csr_write(ask4b6b_pkg::REG_HEADER_FLAGS, flags_v);
      csr_write(ask4b6b_pkg::REG_MAX_MSG_LEN, limit_v);
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_framing();
      send_start(8'd0);
      send_start(8'd1);
      send_data(8'h00);
      send_start(8'd2);
      send_data(8'hff);
      send_data(8'h0f);
      send_data(8'ha5);
      send_start(8'd61);
      send_start(8'd255);
      send_start(8'd3);
      send_data(8'hf0);
      send_start(8'd1);
      send_data(8'h3c);
      send_data(8'h11);
      send_start(8'd8);
      send_data(8'h01);
      send_data(8'h23);
      send_data(8'h45);
      send_data(8'h67);
      send_data(8'h89);
      send_data(8'hab);
      send_data(8'hcd);
      send_data(8'hef);
   endtask

   task automatic test_register_settings();
      apply_settings(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_start(8'd0);
      send_start(8'd1);
      send_data(8'h5a);
      wait_idle();
      for (int i = int'(ask4b6b_pkg::REG_MAX_MSG_LEN) + 1;
           i < 2 ** ask4b6b_pkg::CSR_INDEX_W; i++)
         csr_write(ask4b6b_pkg::CSR_INDEX_W'(i), 8'hff);
      csr_valid <= 1'b0;
      send_start(8'd0);
      send_start(8'd1);
      apply_settings(8'hff, 8'hff, 8'hff, 8'hff, 8'd248);
      send_start(8'd248);
      send_data(8'h80);
      send_data(8'h7f);
      send_start(8'd249);
      send_data(8'h55);
      send_start(8'd0);
      apply_settings(8'ha5, 8'h5a, 8'h01, 8'h80, 8'd255);
      send_start(8'd249);
      send_data(8'hc3);
      send_data(8'h3c);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_start(8'd255);
      repeat (LONG_RUN_BYTES) send_data(8'($urandom));
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_backpressure();
      apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd60);
      req_gaps     = 1'b0;
      hold_request = HOLD_CYCLES;
      send_start(8'd12);
      repeat (6) send_data(8'($urandom));
      wait_drained();
      req_gaps = 1'b1;
      repeat (6) send_data(8'($urandom));
      send_start(8'd0);
      send_start(8'd2);
      wait_drained();
      send_data(8'($urandom));
      send_data(8'($urandom));
   endtask

   task automatic test_random_packets();
      int sent;
      int pick;
      int plen;
      int nsend;
      int cap;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: cap = 60;
            1: cap = 0;
            2: cap = 255;
            3: cap = $urandom_range(1, 30);
            default: cap = 248;
         endcase
         apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'(cap));
         req_gaps = (phase != 3);
         rsp_gaps = (phase != 3);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0 && payload_left == 8'd0) begin
               send_data(8'($urandom));
            end else if (pick <= 2 && len_limit < 8'd255) begin
               send_start(8'($urandom_range(int'(len_limit) + 1, 255)));
               sent++;
            end else begin
               plen = $urandom_range(0, (len_limit < 8'd10) ? int'(len_limit) : 10);
               if (pick == 3)
                  plen = $urandom_range(0, (len_limit < 8'd64) ? int'(len_limit) : 64);
               nsend = plen;
               if (pick == 4 && plen > 0) nsend = $urandom_range(0, plen - 1);
               send_start(8'(plen));
               sent++;
               repeat (nsend) begin
                  send_data(8'($urandom));
                  sent++;
               end
            end
         end
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_framing();
      test_register_settings();
      test_backpressure();
      test_random_packets();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/ask4b6b_pkg.sv
rtl/ask4b6b_queue.sv
rtl/ask4b6b_front.sv
rtl/ask4b6b_back.sv
rtl/ask_packet_4b6b_framer_top.sv
dv/tb_ask_packet_4b6b_framer_top.sv
